// ===== src/shfx_pkg.sv =====
// ---------------------------------------------------------------------------
// shfx_pkg - shared types and constants for the sync header frame checker
// Header bytes, frame geometry, the front-to-back command and the port
// structs between the front end, the command queue and the back end.
// ---------------------------------------------------------------------------
package shfx_pkg;

	localparam logic [7:0] HDR0 = 8'hBD;
	localparam logic [7:0] HDR1 = 8'hDB;
	localparam logic [7:0] HDR2 = 8'h0B;

	localparam logic [5:0] CHECK1_POS = 6'd57;
	localparam logic [5:0] CHECK2_POS = 6'd62;   // also the last frame index
	localparam logic [5:0] POS_HDR0   = 6'd0;
	localparam logic [5:0] POS_HDR1   = 6'd1;
	localparam logic [5:0] POS_HDR2   = 6'd2;

	// Two frame banks of 64 slots each, bank in the address msb
	localparam int BUF_DEPTH = 128;

	// Frame outcome passed from front to back
	typedef struct packed {
		logic ok;     // both checksums matched
		logic bank;   // bank holding the frame bytes
	} cmd_t;

	// Frame buffer write port
	typedef struct packed {
		logic       en;
		logic [6:0] addr;
		logic [7:0] data;
	} wr_t;

	// Bank handed back once drained
	typedef struct packed {
		logic en;
		logic bank;
	} rel_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_FETCH,
		B_LOAD,
		B_HOLD
	} back_state_t;

endpackage

// ===== src/sync_header_frame_xor_checker.sv =====
// ---------------------------------------------------------------------------
// sync_header_frame_xor_checker - sync header deframer with XOR checksums
// Hunts for header BD DB 0B, collects 63-byte frames, checks the XOR of
// bytes 0..56 against byte 57 and of bytes 0..61 against byte 62, then
// streams out a verified frame or one error result.
// ---------------------------------------------------------------------------
//
//  channel  | dir | tdata (lsb up)                        | tlast | tuser
//  ---------+-----+---------------------------------------+-------+--------
//  s_axis   | in  | [7:0] data_byte                       |  -    |  -
//  m_axis   | out | [7:0] frame_byte, [13:8] byte_index,  | last  | status
//           |     | [15:14] zero                          |       |
//
//  Flow: the front end takes one byte per cycle while s_axis_tready is high.
//  A verified frame drains result by result: output register load, then the
//  transfer, which also issues the next frame buffer read; the pop and the
//  first fetch come before the first load. An error result is presented
//  the cycle after its command is popped.
//  Buffering: two frame banks. s_axis_tready drops while the bank being
//  filled still holds an undrained frame or the two-entry command queue is
//  full. Reset: all control state clears at once; the frame buffer is not
//  cleared, only slots already written in the current frame are read.
//  Stalls on m_axis hold the output register and never lose a transfer.
// ---------------------------------------------------------------------------
module sync_header_frame_xor_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] frame_byte, [13:8] byte_index, [15:14] 0
	output logic        m_axis_tlast,   // last result of the frame
	output logic        m_axis_tuser    // [0] status: 1 = checksum failed
);

	shfx_pkg::cmd_t push_cmd;
	shfx_pkg::cmd_t head;
	shfx_pkg::wr_t  wr;
	shfx_pkg::rel_t rel;

	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_empty;
	logic [7:0] out_byte;
	logic [5:0] out_index;

	// Front: hunt, collect, checksum; one command per finished frame
	shfx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd),
		.wr       (wr),
		.rel      (rel)
	);

	// Decouples frame completion from the result drain
	shfx_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Back: frame buffer and result sequencer
	shfx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.head       (head),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.rel        (rel),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (out_byte),
		.out_index  (out_index),
		.out_last   (m_axis_tlast),
		.out_status (m_axis_tuser)
	);

	assign m_axis_tdata = {2'b00, out_index, out_byte};

endmodule

// ===== src/shfx_front.sv =====
// ---------------------------------------------------------------------------
// shfx_front - header hunt, byte collection and checksum evaluation
// Stores frame bytes into the current bank, tracks the running XOR and
// queues one command per completed frame.
// ---------------------------------------------------------------------------
module shfx_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               q_full,
	output logic               q_push,
	output shfx_pkg::cmd_t     q_cmd,
	output shfx_pkg::wr_t      wr,
	input  shfx_pkg::rel_t     rel
);

	logic [5:0] fill_q;
	logic [7:0] xor_q;
	logic       chk1_q;
	logic       bank_q;
	logic [1:0] busy_q;

	logic       accept;
	logic       store;
	logic       restart;
	logic       complete;
	logic [1:0] set_mask;
	logic [1:0] clr_mask;

	assign in_ready = !busy_q[bank_q] && !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		store    = 1'b0;
		restart  = 1'b0;
		complete = 1'b0;
		case (fill_q)
			shfx_pkg::POS_HDR0: begin
				store = (in_byte == shfx_pkg::HDR0);
			end
			shfx_pkg::POS_HDR1: begin
				store   = (in_byte == shfx_pkg::HDR1);
				restart = !store;
			end
			shfx_pkg::POS_HDR2: begin
				store   = (in_byte == shfx_pkg::HDR2);
				restart = !store;
			end
			default: begin
				if (fill_q > shfx_pkg::CHECK2_POS) begin
					restart = 1'b1;
				end else begin
					store    = 1'b1;
					complete = (fill_q == shfx_pkg::CHECK2_POS);
				end
			end
		endcase
	end

	assign q_push      = accept && complete;
	assign q_cmd.ok    = chk1_q && (xor_q == in_byte);
	assign q_cmd.bank  = bank_q;

	assign wr.en   = accept && store;
	assign wr.addr = {bank_q, fill_q};
	assign wr.data = in_byte;

	assign set_mask = (q_push && q_cmd.ok) ? (2'b01 << bank_q) : 2'b00;
	assign clr_mask = rel.en ? (2'b01 << rel.bank) : 2'b00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			xor_q  <= '0;
			chk1_q <= 1'b0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			busy_q <= (busy_q & ~clr_mask) | set_mask;
			if (accept) begin
				if (restart || complete) begin
					fill_q <= '0;
					xor_q  <= '0;
					chk1_q <= 1'b0;
				end else if (store) begin
					fill_q <= 6'(fill_q + 6'd1);
					xor_q  <= xor_q ^ in_byte;
					if (fill_q == shfx_pkg::CHECK1_POS) begin
						chk1_q <= (xor_q == in_byte);
					end
				end
				if (q_push && q_cmd.ok) begin
					bank_q <= !bank_q;
				end
			end
		end
	end

endmodule

// ===== src/shfx_cmdq.sv =====
// ---------------------------------------------------------------------------
// shfx_cmdq - two-entry command queue between front and back
// Simple FIFO of frame commands; push and pop may happen together.
// ---------------------------------------------------------------------------
module shfx_cmdq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  shfx_pkg::cmd_t     push_cmd,
	input  logic               pop,
	output shfx_pkg::cmd_t     head,
	output logic               full,
	output logic               empty
);

	shfx_pkg::cmd_t entry_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= 2'(count_q + 2'd1);
				2'b01:   count_q <= 2'(count_q - 2'd1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/shfx_back.sv =====
// ---------------------------------------------------------------------------
// shfx_back - frame buffer and result sequencer
// Holds the two-bank frame buffer, drains verified frames byte by byte
// through an output register and emits one error result for a bad frame.
// ---------------------------------------------------------------------------
module shfx_back (
	input  logic               clk,
	input  logic               arst_n,
	input  shfx_pkg::wr_t      wr,
	input  shfx_pkg::cmd_t     head,
	input  logic               q_empty,
	output logic               q_pop,
	output shfx_pkg::rel_t     rel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic [5:0]         out_index,
	output logic               out_last,
	output logic               out_status
);

	logic [7:0] mem [shfx_pkg::BUF_DEPTH];
	logic [7:0] rdata_q;

	shfx_pkg::back_state_t st_q;
	shfx_pkg::back_state_t st_d;

	logic       bank_q;
	logic       err_q;
	logic [5:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;

	logic       accept;
	logic       at_last;
	logic       rd_en;
	logic [6:0] rd_addr;

	assign accept  = out_valid_q && out_ready;
	assign at_last = (idx_q == shfx_pkg::CHECK2_POS);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			shfx_pkg::B_IDLE: begin
				if (!q_empty) begin
					st_d = head.ok ? shfx_pkg::B_FETCH : shfx_pkg::B_HOLD;
				end
			end
			shfx_pkg::B_FETCH: st_d = shfx_pkg::B_LOAD;
			shfx_pkg::B_LOAD:  st_d = shfx_pkg::B_HOLD;
			shfx_pkg::B_HOLD: begin
				if (accept) begin
					st_d = (err_q || at_last) ? shfx_pkg::B_IDLE : shfx_pkg::B_LOAD;
				end
			end
			default: st_d = shfx_pkg::B_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop    = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = {bank_q, idx_q};
		rel.en   = 1'b0;
		rel.bank = bank_q;
		case (st_q)
			shfx_pkg::B_IDLE: begin
				q_pop = !q_empty;
			end
			shfx_pkg::B_FETCH: begin
				rd_en = 1'b1;
			end
			shfx_pkg::B_HOLD: begin
				// next read overlaps the transfer of the current byte
				rd_en   = accept && !err_q && !at_last;
				rd_addr = {bank_q, 6'(idx_q + 6'd1)};
				rel.en  = accept && !err_q && at_last;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_byte_q <= '0;
		end else if (st_q == shfx_pkg::B_LOAD) begin
			out_byte_q <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= shfx_pkg::B_IDLE;
			bank_q      <= 1'b0;
			err_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (q_pop) begin
				bank_q      <= head.bank;
				err_q       <= !head.ok;
				idx_q       <= '0;
				out_valid_q <= !head.ok;
			end else if (st_q == shfx_pkg::B_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (accept) begin
				out_valid_q <= 1'b0;
				if (rd_en) begin
					idx_q <= 6'(idx_q + 6'd1);
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign out_index  = idx_q;
	assign out_last   = err_q || at_last;
	assign out_status = err_q;

endmodule
